@@ hw/rtl/qbv_pkg.sv @@
package qbv_pkg;

    // Data path sizes
    localparam int COMP_W          = 32;
    localparam int SQRT_W          = 64;
    localparam int SQRT_STEPS      = SQRT_W / 2;
    localparam int DIV_W           = 32;
    localparam int UNIT_DIV_STEPS  = 31;
    localparam int CROSS_DIV_STEPS = 32;

    // Latencies in clock cycles
    localparam int LAT_UNIT  = 4 + SQRT_STEPS + 1 + UNIT_DIV_STEPS + 1;
    localparam int LAT_NORM  = SQRT_STEPS + 1 + CROSS_DIV_STEPS + 1;
    localparam int NORM_PAD  = LAT_UNIT - LAT_NORM;
    localparam int LAT_TOTAL = 2 * LAT_UNIT + 4;

    // Thresholds: -1 + 0.001 in Q30, and 0.01 in Q60
    localparam logic signed [34:0] DOT_OPP_LIMIT = -35'sd1072668082;
    localparam logic signed [63:0] PARALLEL_LIM  = 64'sd11529215046068470;
    localparam logic signed [31:0] IDENT_W       = 32'sh4000_0000;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] dest_x;
        logic signed [31:0] dest_y;
        logic signed [31:0] dest_z;
    } qbv_in_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               opposite_case;
        logic               zero_length;
    } qbv_out_t;

    // Index 0 is x, 1 is y, 2 is z
    typedef logic [2:0][COMP_W-1:0] vec3_t;

    typedef struct packed {
        logic [SQRT_W-1:0] x;
        logic [33:0]       rem;
        logic [31:0]       root;
    } sqrt_st_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } div_st_t;

    // One digit of the square root: two radicand bits, one root bit
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        sqrt_st_t    n;
        logic [35:0] cur;
        logic [35:0] trial;
        cur   = {s.rem, s.x[SQRT_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        n.x   = {s.x[SQRT_W-3:0], 2'b00};
        if (cur >= trial) begin
            n.rem  = 34'(cur - trial);
            n.root = {s.root[30:0], 1'b1};
        end else begin
            n.rem  = cur[33:0];
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    // One quotient bit of a restoring division
    function automatic div_st_t div_step(input div_st_t s, input logic [DIV_W-1:0] den);
        div_st_t      n;
        logic [DIV_W:0] cur;
        cur   = {s.rem, s.num[DIV_W-1]};
        n.num = {s.num[DIV_W-2:0], 1'b0};
        if (cur >= {1'b0, den}) begin
            n.rem = DIV_W'(cur - {1'b0, den});
            n.quo = {s.quo[DIV_W-2:0], 1'b1};
        end else begin
            n.rem = cur[DIV_W-1:0];
            n.quo = {s.quo[DIV_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // Apply sign to a magnitude and clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic neg, input logic [31:0] mag);
        logic signed [31:0] r;
        if (!neg) begin
            r = mag[31] ? 32'sh7fff_ffff : $signed(mag);
        end else begin
            r = mag[31] ? 32'sh8000_0000 : -$signed(mag);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/quaternion_between_vectors_unit.sv @@
// Shortest-arc rotation between two Q16.16 vectors, given as a Q2.30 unit
// quaternion. A transfer is taken at every clock edge where start is high;
// busy is always low, so a new pair may follow in the very next cycle. Each
// result appears on result for one cycle with done high, in order; the
// receiver must take it then. The latency is set by two normalizing units
// in series (each a 32-step square root and a 31-step divider), the second
// of which normalizes the 180-degree axis for nearly opposite vectors, plus
// the product, sum, dot-rounding and output-selection registers. A zero-length
// input yields the identity quaternion with zero_length set.
module quaternion_between_vectors_unit
    import qbv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  qbv_in_t  operands,
    output logic     done,
    output qbv_out_t result
);

    typedef struct packed {
        logic vld;
        logic zero;
        logic opp;
    } flags_t;

    typedef struct packed {
        logic [2:0][63:0] cmag;
        logic [2:0]       cneg;
    } nside_t;

    typedef struct packed {
        logic [2:0] cneg;
        logic [31:0] w;
    } ndside_t;

    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_t;

    logic  accept;
    vec3_t start_vec;
    vec3_t dest_vec;
    logic  us_vld;
    logic  ud_vld;
    vec3_t us;
    vec3_t ud;
    logic  ok_s;
    logic  ok_d;

    logic             vld1_reg;
    logic             zero1_reg;
    logic [2:0][63:0] dp_reg;
    logic [5:0][63:0] cp_reg;
    logic [1:0][63:0] pp_reg;
    vec3_t            us1_reg;

    logic             vld2_reg;
    logic             zero2_reg;
    logic [63:0]      dot2_reg;
    logic [2:0][63:0] cr2_reg;
    logic [63:0]      par2_reg;
    vec3_t            us2_reg;

    vec3_t            axis3_reg;
    logic             ax_vld;
    vec3_t            ax_unit;
    logic             ax_ok;

    flags_t           fl_reg  [0:LAT_UNIT];
    sqrt_st_t         nsq_reg [0:SQRT_STEPS];
    nside_t           ns_reg  [0:SQRT_STEPS];
    div_st_t [2:0]    ndv_reg [0:CROSS_DIV_STEPS];
    logic [DIV_W-1:0] nden_reg[0:CROSS_DIV_STEPS];
    ndside_t          nds_reg [0:CROSS_DIV_STEPS];
    quat_t            npad_reg[0:NORM_PAD];

    logic             done_reg;
    qbv_out_t         result_reg;

    logic [63:0]        dot_mag;
    logic [33:0]        dot_q;
    logic signed [34:0] dot3;
    logic signed [35:0] t3;
    logic               opp3;
    logic [2:0][63:0]   cmag3;
    logic [2:0]         cneg3;
    vec3_t              axis3_next;
    logic [31:0]        s_root;
    logic [2:0][63:0]   nnum;
    flags_t             fl_out;
    quat_t              q_out;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign start_vec = {operands.start_z, operands.start_y, operands.start_x};
    assign dest_vec  = {operands.dest_z, operands.dest_y, operands.dest_x};

    // Normalize both vectors
    qbv_unitize u_start (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec       (start_vec),
        .out_valid (us_vld),
        .unit      (us),
        .ok        (ok_s)
    );

    qbv_unitize u_dest (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec       (dest_vec),
        .out_valid (ud_vld),
        .unit      (ud),
        .ok        (ok_d)
    );

    // Hold the control bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= us_vld;
            vld2_reg <= vld1_reg;
        end
    end

    // Form the dot, cross and parallel-test products of the unit vectors
    always_ff @(posedge clk)
    begin
        dp_reg[0] <= 64'($signed(us[0]) * $signed(ud[0]));
        dp_reg[1] <= 64'($signed(us[1]) * $signed(ud[1]));
        dp_reg[2] <= 64'($signed(us[2]) * $signed(ud[2]));
        cp_reg[0] <= 64'($signed(us[1]) * $signed(ud[2]));
        cp_reg[1] <= 64'($signed(us[2]) * $signed(ud[1]));
        cp_reg[2] <= 64'($signed(us[2]) * $signed(ud[0]));
        cp_reg[3] <= 64'($signed(us[0]) * $signed(ud[2]));
        cp_reg[4] <= 64'($signed(us[0]) * $signed(ud[1]));
        cp_reg[5] <= 64'($signed(us[1]) * $signed(ud[0]));
        pp_reg[0] <= 64'($signed(us[0]) * $signed(us[0]));
        pp_reg[1] <= 64'($signed(us[1]) * $signed(us[1]));
        us1_reg   <= us;
        zero1_reg <= !ok_s || !ok_d;
    end

    // Sum dot product, cross product and parallel test
    always_ff @(posedge clk)
    begin
        dot2_reg   <= dp_reg[0] + dp_reg[1] + dp_reg[2];
        cr2_reg[0] <= cp_reg[0] - cp_reg[1];
        cr2_reg[1] <= cp_reg[2] - cp_reg[3];
        cr2_reg[2] <= cp_reg[4] - cp_reg[5];
        par2_reg   <= pp_reg[0] + pp_reg[1];
        us2_reg    <= us1_reg;
        zero2_reg  <= zero1_reg;
    end

    // Round the dot product, pick the branch and the fallback axis
    always_comb
    begin
        dot_mag = dot2_reg[63] ? (~dot2_reg + 64'd1) : dot2_reg;
        dot_q   = 34'((dot_mag + 64'd536870912) >> 30);
        dot3    = dot2_reg[63] ? -$signed({1'b0, dot_q}) : $signed({1'b0, dot_q});
        opp3    = dot3 < DOT_OPP_LIMIT;
        t3      = 36'sd2 * (36'sd1073741824 + 36'(dot3));
        for (int i = 0; i < 3; i++)
        begin
            cneg3[i] = cr2_reg[i][63];
            cmag3[i] = cr2_reg[i][63] ? (~cr2_reg[i] + 64'd1) : cr2_reg[i];
        end
        if ($signed(par2_reg) < PARALLEL_LIM)
        begin
            axis3_next[0] = '0;
            axis3_next[1] = ~us2_reg[2] + 32'd1;
            axis3_next[2] = us2_reg[1];
        end
        else
        begin
            axis3_next[0] = ~us2_reg[1] + 32'd1;
            axis3_next[1] = us2_reg[0];
            axis3_next[2] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAT_UNIT; k++)
            begin
                fl_reg[k] <= '0;
            end
        end
        else
        begin
            fl_reg[0].vld  <= vld2_reg;
            fl_reg[0].zero <= zero2_reg;
            fl_reg[0].opp  <= opp3 && !zero2_reg;
            for (int k = 1; k <= LAT_UNIT; k++)
            begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        axis3_reg       <= axis3_next;
        nsq_reg[0].x    <= 64'(t3[33:0]) << 30;
        nsq_reg[0].rem  <= '0;
        nsq_reg[0].root <= '0;
        ns_reg[0].cmag  <= cmag3;
        ns_reg[0].cneg  <= cneg3;
    end

    // Normalize the fallback axis; its valid travels with axis3_reg
    qbv_unitize u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fl_reg[0].vld),
        .vec       (axis3_reg),
        .out_valid (ax_vld),
        .unit      (ax_unit),
        .ok        (ax_ok)
    );

    // Square root of 2(1+d), one digit per stage
    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_nsqrt
        always_ff @(posedge clk)
        begin
            nsq_reg[k] <= sqrt_step(nsq_reg[k-1]);
            ns_reg[k]  <= ns_reg[k-1];
        end
    end

    // Load the cross dividers with |c| + s/2 over s
    assign s_root = nsq_reg[SQRT_STEPS].root;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nnum[i] = ns_reg[SQRT_STEPS].cmag[i] + 64'(s_root >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ndv_reg[0][i].rem <= nnum[i][63:32];
            ndv_reg[0][i].num <= nnum[i][31:0];
            ndv_reg[0][i].quo <= '0;
        end
        nden_reg[0]     <= s_root;
        nds_reg[0].cneg <= ns_reg[SQRT_STEPS].cneg;
        nds_reg[0].w    <= 32'((33'(s_root) + 33'd1) >> 1);
    end

    // Divide the cross product, one quotient bit per stage
    for (genvar k = 1; k <= CROSS_DIV_STEPS; k++)
    begin : g_ndiv
        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ndv_reg[k][i] <= div_step(ndv_reg[k-1][i], nden_reg[k-1]);
            end
            nden_reg[k] <= nden_reg[k-1];
            nds_reg[k]  <= nds_reg[k-1];
        end
    end

    // Apply signs, saturate, and pad to the axis unit's latency
    always_ff @(posedge clk)
    begin
        npad_reg[0].w <= sat32(1'b0, nds_reg[CROSS_DIV_STEPS].w);
        npad_reg[0].x <= sat32(nds_reg[CROSS_DIV_STEPS].cneg[0], ndv_reg[CROSS_DIV_STEPS][0].quo);
        npad_reg[0].y <= sat32(nds_reg[CROSS_DIV_STEPS].cneg[1], ndv_reg[CROSS_DIV_STEPS][1].quo);
        npad_reg[0].z <= sat32(nds_reg[CROSS_DIV_STEPS].cneg[2], ndv_reg[CROSS_DIV_STEPS][2].quo);
        for (int k = 1; k <= NORM_PAD; k++)
        begin
            npad_reg[k] <= npad_reg[k-1];
        end
    end

    // Select identity, half-turn or normal result
    always_comb
    begin
        fl_out = fl_reg[LAT_UNIT];
        if (fl_out.zero)
        begin
            q_out.w = IDENT_W;
            q_out.x = '0;
            q_out.y = '0;
            q_out.z = '0;
        end
        else if (fl_out.opp)
        begin
            q_out.w = '0;
            q_out.x = ax_ok ? $signed(ax_unit[0]) : '0;
            q_out.y = ax_ok ? $signed(ax_unit[1]) : '0;
            q_out.z = ax_ok ? $signed(ax_unit[2]) : '0;
        end
        else
        begin
            q_out = npad_reg[NORM_PAD];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fl_out.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.quat_w        <= q_out.w;
        result_reg.quat_x        <= q_out.x;
        result_reg.quat_y        <= q_out.y;
        result_reg.quat_z        <= q_out.z;
        result_reg.opposite_case <= fl_out.opp;
        result_reg.zero_length   <= fl_out.zero;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        us_vld == ud_vld)
        else $error("normalizing units out of step");

    a_axis_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ax_vld == fl_reg[LAT_UNIT].vld)
        else $error("axis unit out of step with flags");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.opposite_case && result.zero_length))
        else $error("both special cases flagged");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_length |-> result.quat_w == IDENT_W && result.quat_x == 0
            && result.quat_y == 0 && result.quat_z == 0)
        else $error("zero-length result is not identity");

    a_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.opposite_case |-> result.quat_w == 0)
        else $error("half-turn result has nonzero scalar");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT_TOTAL))
        else $error("result without a transfer");
`endif

endmodule

@@ hw/rtl/qbv_unitize.sv @@
module qbv_unitize
    import qbv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  vec3_t vec,
    output logic  out_valid,
    output vec3_t unit,
    output logic  ok
);

    typedef struct packed {
        logic [2:0][29:0] an;
        logic [2:0]       neg;
        logic             ok;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       ok;
    } dside_t;

    // Dividend of one component: a*2^30 + r/2
    function automatic logic [60:0] numer_of(input logic [29:0] a, input logic [31:0] r);
        return {1'b0, a, 30'd0} + 61'(r >> 1);
    endfunction

    logic [LAT_UNIT-1:0] vld_reg;

    logic [2:0][31:0] abs0_reg;
    logic [2:0]       neg0_reg;
    logic [31:0]      max0_reg;

    logic [2:0][29:0] an1_reg;
    logic [2:0]       neg1_reg;
    logic             ok1_reg;

    logic [2:0][59:0] sq2_reg;
    side_t            side2_reg;

    sqrt_st_t sq_reg   [0:SQRT_STEPS];
    side_t    side_reg [0:SQRT_STEPS];

    div_st_t  [2:0]   dv_reg  [0:UNIT_DIV_STEPS];
    logic [DIV_W-1:0] den_reg [0:UNIT_DIV_STEPS];
    dside_t           ds_reg  [0:UNIT_DIV_STEPS];

    vec3_t unit_reg;
    logic  ok_reg;

    logic [2:0][31:0] abs0_next;
    logic [2:0]       neg0_next;
    logic [31:0]      max0_next;
    logic [4:0]       msb;
    logic [2:0][29:0] an1_next;
    logic [31:0]      root;
    logic [2:0][60:0] numer;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT_UNIT-2:0], in_valid};
        end
    end

    // Take magnitudes and the largest one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg0_next[i] = vec[i][31];
            abs0_next[i] = vec[i][31] ? (~vec[i] + 32'd1) : vec[i];
        end
        max0_next = abs0_next[0];
        if (abs0_next[1] > max0_next)
        begin
            max0_next = abs0_next[1];
        end
        if (abs0_next[2] > max0_next)
        begin
            max0_next = abs0_next[2];
        end
    end

    always_ff @(posedge clk)
    begin
        abs0_reg <= abs0_next;
        neg0_reg <= neg0_next;
        max0_reg <= max0_next;
    end

    // Block-shift so that the largest magnitude lies in [2^29, 2^30)
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (max0_reg[i])
            begin
                msb = 5'(i);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (msb > 5'd29)
            begin
                an1_next[i] = 30'(abs0_reg[i] >> (msb - 5'd29));
            end
            else
            begin
                an1_next[i] = 30'(abs0_reg[i] << (5'd29 - msb));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        an1_reg  <= an1_next;
        neg1_reg <= neg0_reg;
        ok1_reg  <= (max0_reg != 32'd0);
    end

    // Square the components
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i] <= an1_reg[i] * an1_reg[i];
        end
        side2_reg.an  <= an1_reg;
        side2_reg.neg <= neg1_reg;
        side2_reg.ok  <= ok1_reg;
    end

    // Sum the squares into the root unit
    always_ff @(posedge clk)
    begin
        sq_reg[0].x    <= 64'(sq2_reg[0]) + 64'(sq2_reg[1]) + 64'(sq2_reg[2]);
        sq_reg[0].rem  <= '0;
        sq_reg[0].root <= '0;
        side_reg[0]    <= side2_reg;
    end

    // Square root, one digit per stage
    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            sq_reg[k]   <= sqrt_step(sq_reg[k-1]);
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Load the dividers with a*2^30 + r/2 over r
    assign root = sq_reg[SQRT_STEPS].root;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            numer[i] = numer_of(side_reg[SQRT_STEPS].an[i], root);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dv_reg[0][i].rem <= 32'(numer[i] >> 31);
            dv_reg[0][i].num <= {numer[i][30:0], 1'b0};
            dv_reg[0][i].quo <= '0;
        end
        den_reg[0]    <= root;
        ds_reg[0].neg <= side_reg[SQRT_STEPS].neg;
        ds_reg[0].ok  <= side_reg[SQRT_STEPS].ok;
    end

    // Divide, one quotient bit per stage
    for (genvar k = 1; k <= UNIT_DIV_STEPS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[k][i] <= div_step(dv_reg[k-1][i], den_reg[k-1]);
            end
            den_reg[k] <= den_reg[k-1];
            ds_reg[k]  <= ds_reg[k-1];
        end
    end

    // Restore signs; drop to zero for an all-zero vector
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!ds_reg[UNIT_DIV_STEPS].ok)
            begin
                unit_reg[i] <= '0;
            end
            else
            begin
                unit_reg[i] <= sat32(ds_reg[UNIT_DIV_STEPS].neg[i],
                                     dv_reg[UNIT_DIV_STEPS][i].quo);
            end
        end
        ok_reg <= ds_reg[UNIT_DIV_STEPS].ok;
    end

    assign out_valid = vld_reg[LAT_UNIT-1];
    assign unit      = unit_reg;
    assign ok        = ok_reg;

endmodule

@@ test/quaternion_between_vectors_unit_tb.sv @@
module quaternion_between_vectors_unit_tb;
    import qbv_pkg::*;

    localparam longint ONE_Q30    = 64'sd1 << 30;
    localparam longint OPP_MARGIN = 64'sd1073742;
    localparam longint PAR_LIM    = 64'sd11529215046068470;
    localparam int     DRAIN      = 200;
    localparam longint CYCLE_CAP  = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    qbv_in_t  operands;
    logic     done;
    qbv_out_t result;

    qbv_out_t expected_quats[$];
    int       error_count = 0;
    int       pairs_sent;
    int       quats_checked = 0;
    int       opp_seen = 0;
    int       zero_seen = 0;
    longint   cycle_count = 0;

    quaternion_between_vectors_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Signed by positive division, rounded half away from zero
    function automatic longint div_half_away(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? 64'd0 - longint'(num) : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Unit vector in Q30; returns 0 for an all-zero vector
    function automatic bit unit_q30(input longint c[3], output longint u[3]);
        longint unsigned a[3];
        longint unsigned m;
        longint unsigned r;
        longint unsigned q;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = c[i] < 0 ? 64'd0 - longint'(c[i]) : c[i];
            if (a[i] > m) m = a[i];
        end
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (m == 0) return 1'b0;
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        r = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = ((a[i] << 30) + r / 2) / r;
            u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // Q30 value clamped to the Q2.30 port
    function automatic logic signed [31:0] clamp_q30(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Shortest-arc quaternion for one vector pair
    function automatic qbv_out_t rotation_between(input qbv_in_t p);
        longint   sv[3], dv[3], us[3], ud[3], ax[3], n[3], q[4];
        longint   dot, cx, cy, cz;
        longint unsigned s;
        bit       ok_s, ok_d;
        qbv_out_t o;
        sv = '{longint'(p.start_x), longint'(p.start_y), longint'(p.start_z)};
        dv = '{longint'(p.dest_x), longint'(p.dest_y), longint'(p.dest_z)};
        q = '{0, 0, 0, 0};
        o = '0;
        ok_s = unit_q30(sv, us);
        ok_d = unit_q30(dv, ud);
        if (!ok_s || !ok_d)
        begin
            o.zero_length = 1'b1;
            q[0] = ONE_Q30;
        end
        else
        begin
            dot = div_half_away(us[0] * ud[0] + us[1] * ud[1] + us[2] * ud[2], 64'd1 << 30);
            if (dot < -ONE_Q30 + OPP_MARGIN)
            begin
                o.opposite_case = 1'b1;
                ax = '{-us[1], us[0], 0};
                if (us[0] * us[0] + us[1] * us[1] < PAR_LIM)
                    ax = '{0, -us[2], us[1]};
                void'(unit_q30(ax, n));
                q[1] = n[0];
                q[2] = n[1];
                q[3] = n[2];
            end
            else
            begin
                s = int_sqrt(longint'(2 * (ONE_Q30 + dot)) << 30);
                cx = us[1] * ud[2] - us[2] * ud[1];
                cy = us[2] * ud[0] - us[0] * ud[2];
                cz = us[0] * ud[1] - us[1] * ud[0];
                q[0] = div_half_away(longint'(s), 2);
                q[1] = div_half_away(cx, s);
                q[2] = div_half_away(cy, s);
                q[3] = div_half_away(cz, s);
            end
        end
        o.quat_w = clamp_q30(q[0]);
        o.quat_x = clamp_q30(q[1]);
        o.quat_y = clamp_q30(q[2]);
        o.quat_z = clamp_q30(q[3]);
        return o;
    endfunction

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        qbv_out_t exp_q;
        if (rst_n && done)
        begin
            if (expected_quats.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                quats_checked++;
                if (exp_q.opposite_case) opp_seen++;
                if (exp_q.zero_length) zero_seen++;
                if (result.quat_w !== exp_q.quat_w)
                begin
                    $error("quat_w exp %0d got %0d", exp_q.quat_w, result.quat_w);
                    error_count++;
                end
                if (result.quat_x !== exp_q.quat_x)
                begin
                    $error("quat_x exp %0d got %0d", exp_q.quat_x, result.quat_x);
                    error_count++;
                end
                if (result.quat_y !== exp_q.quat_y)
                begin
                    $error("quat_y exp %0d got %0d", exp_q.quat_y, result.quat_y);
                    error_count++;
                end
                if (result.quat_z !== exp_q.quat_z)
                begin
                    $error("quat_z exp %0d got %0d", exp_q.quat_z, result.quat_z);
                    error_count++;
                end
                if (result.opposite_case !== exp_q.opposite_case)
                begin
                    $error("opposite_case exp %0b got %0b",
                           exp_q.opposite_case, result.opposite_case);
                    error_count++;
                end
                if (result.zero_length !== exp_q.zero_length)
                begin
                    $error("zero_length exp %0b got %0b",
                           exp_q.zero_length, result.zero_length);
                    error_count++;
                end
            end
        end
    end

    int burst_left;

    // Send one pair, honouring the sender's burst and gap pattern
    task automatic send_pair(input qbv_in_t p);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        start    <= 1'b1;
        operands <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_quats.push_back(rotation_between(p));
        pairs_sent++;
    endtask

    task automatic idle_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_quats.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 6))) - 3;
            3: return $signed(32'($urandom_range(0, 131072))) - 65536;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic qbv_in_t make_pair(input logic signed [31:0] sx, sy, sz, dx, dy, dz);
        qbv_in_t p;
        p.start_x = sx;
        p.start_y = sy;
        p.start_z = sz;
        p.dest_x  = dx;
        p.dest_y  = dy;
        p.dest_z  = dz;
        return p;
    endfunction

    // Extremes, zero vectors, identical, opposite and axis fallback
    task automatic test_directed();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        send_pair(make_pair(0, 0, 0, 65536, 0, 0));
        send_pair(make_pair(65536, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0));
        send_pair(make_pair(65536, 0, 0, 65536, 0, 0));
        send_pair(make_pair(65536, 0, 0, 0, 65536, 0));
        send_pair(make_pair(65536, 0, 0, -65536, 0, 0));
        send_pair(make_pair(0, 65536, 0, 0, -65536, 0));
        send_pair(make_pair(0, 0, 65536, 0, 0, -65536));
        send_pair(make_pair(1, 0, 1000, -1, 0, -1000));
        send_pair(make_pair(0, 1, 0, 0, -1, 0));
        send_pair(make_pair(mx, mx, mx, mn, mn, mn));
        send_pair(make_pair(mn, mn, mn, mx, mx, mx));
        send_pair(make_pair(mn, 0, 0, mx, 0, 0));
        send_pair(make_pair(mx, mn, mx, mn, mx, mn));
        send_pair(make_pair(1, 1, 1, -1, -1, -1));
        send_pair(make_pair(-1, 0, 0, 0, 0, -1));
        send_pair(make_pair(mx, 1, -1, mx, -1, 1));
        send_pair(make_pair(3, 4, 0, -3, -4, 1));
        send_pair(make_pair(-65536, -65536, 0, 65536, 65536, 0));
        send_pair(make_pair(32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 0, 32'sh5555_5555));
    endtask

    // Random pairs: mostly free, some nearly opposite, identical, on the z axis or with a zero vector
    task automatic test_random(input int count);
        qbv_in_t p;
        for (int i = 0; i < count; i++)
        begin
            p = make_pair(rand_comp(), rand_comp(), rand_comp(),
                          rand_comp(), rand_comp(), rand_comp());
            case ($urandom_range(0, 9))
                0: {p.dest_x, p.dest_y, p.dest_z} = {-p.start_x, -p.start_y,
                       -p.start_z + $signed(32'($urandom_range(0, 4))) - 2};
                1: {p.dest_x, p.dest_y, p.dest_z} = {p.start_x, p.start_y, p.start_z};
                2: {p.start_x, p.start_y} = '0;
                3: {p.start_x, p.start_y, p.start_z} = '0;
                default: ;
            endcase
            send_pair(p);
        end
    endtask

    task automatic test_back_to_back(input int count);
        qbv_in_t p;
        for (int i = 0; i < count; i++)
        begin
            p = make_pair($signed($urandom()), $signed($urandom()), $signed($urandom()),
                          $signed($urandom()), $signed($urandom()), $signed($urandom()));
            start    <= 1'b1;
            operands <= p;
            @(posedge clk);
            while (busy) @(posedge clk);
            expected_quats.push_back(rotation_between(p));
            pairs_sent++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        operands      = '0;
        pairs_sent    = 0;
        burst_left    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        idle_until_drained();
        test_random(1000);
        idle_until_drained();
        test_back_to_back(300);
        test_random(630);
        idle_until_drained();

        repeat (DRAIN) @(posedge clk);
        $display("Covered %0d vector pairs, %0d results checked (%0d opposite, %0d zero).",
                 pairs_sent, quats_checked, opp_seen, zero_seen);
        if (error_count == 0 && expected_quats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ quaternion_between_vectors_unit.f @@
hw/rtl/qbv_pkg.sv
hw/rtl/qbv_unitize.sv
hw/rtl/quaternion_between_vectors_unit.sv
test/quaternion_between_vectors_unit_tb.sv
